// ----- rtl/gmi_pkg.sv -----
`default_nettype none
package gmi_pkg;
    localparam int unsigned MAP_DEPTH_DEF = 4096;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_MARKER = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] position;
        logic [31:0] map_centimorgan;
    } req_t;

    typedef struct packed {
        logic [31:0] marker_index;
        logic [31:0] genetic_pos;
        logic [63:0] rec_rate;
        logic        rate_valid;
        logic        rate_saturated;
        logic        map_error;
        logic        last;
    } res_t;

    // divider control between sequencer and divider
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;
endpackage
`default_nettype wire

// ----- rtl/gmi_if.sv -----
`default_nettype none
interface gmi_req_if;
    logic          valid;
    logic          ready;
    gmi_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gmi_res_if;
    logic          valid;
    logic          ready;
    gmi_pkg::res_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/gmi_ram.sv -----
`default_nettype none
module gmi_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/gmi_div.sv -----
`default_nettype none
// restoring divider, one quotient bit per cycle: 128/64 -> 64 bit quotient
module gmi_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gmi_pkg::div_ctl_t ctl,
    input  wire logic [127:0]      dividend,
    input  wire logic [63:0]       divisor,
    output gmi_pkg::div_sts_t      sts,
    output logic [63:0]            quotient
);
    logic [6:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [64:0]  rem_reg;
    logic [127:0] num_reg;
    logic [63:0]  den_reg;
    logic [64:0]  shifted;
    logic         ge;

    assign shifted = {rem_reg[63:0], num_reg[127]};
    assign ge      = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd127)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= '0;
            num_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? shifted - {1'b0, den_reg} : shifted;
            num_reg <= {num_reg[126:0], ge};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = num_reg[63:0];
endmodule
`default_nettype wire

// ----- rtl/genetic_map_interpolator_core.sv -----
// channel | dir | payload
// req     | in  | req_type, position, map_centimorgan
// res     | out | marker_index, genetic_pos, rec_rate, flags, last
// A load is taken in the idle state. A marker pays for each cursor step (one RAM
// read and its wait) and for up to two runs of the shared bit-serial divider
// (interpolation, rate). Morgan scaling is a reciprocal multiply, registered in
// S_MORG and S_MWAIT. Marker one gives two results: one for marker zero, then
// its own.
// Reset is asynchronous; no clearing pass, unwritten entries are never read.
// The block takes no request while a marker is in work or a result waits.
`default_nettype none
module genetic_map_interpolator_core #(
    parameter int unsigned MAP_DEPTH = gmi_pkg::MAP_DEPTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    gmi_req_if.sink     req,
    gmi_res_if.source   res
);
    localparam int unsigned AW = $clog2(MAP_DEPTH);
    localparam int unsigned CW = AW + 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD     = 4'd1;
    localparam logic [3:0] S_WALK   = 4'd2;
    localparam logic [3:0] S_PREV   = 4'd3;
    localparam logic [3:0] S_PREVW  = 4'd4;
    localparam logic [3:0] S_INTP   = 4'd5;
    localparam logic [3:0] S_IWAIT  = 4'd6;
    localparam logic [3:0] S_MORG   = 4'd7;
    localparam logic [3:0] S_MWAIT  = 4'd8;
    localparam logic [3:0] S_RATE   = 4'd9;
    localparam logic [3:0] S_RWAIT  = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;
    localparam logic [3:0] S_OUT2   = 4'd12;
    localparam logic [3:0] S_RDW    = 4'd13;

    // ceil(2^35 / 25): exact floor(x / 25) for any 32-bit x after >> 35
    localparam logic [31:0] MORG_RECIP = 32'd1374389535;
    // ceil(2^20 / 25): exact floor(r * 1024 / 25) for r < 25 after >> 10
    localparam logic [19:0] FRAC_RECIP = 20'd41944;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] cur_reg;
    logic [31:0]   mcnt_reg, pg_reg, pp_reg;
    logic [31:0]   bp_reg, p1_reg, c1_reg, cm_reg, g_reg;
    logic [28:0]   morg_q_reg;
    logic [63:0]   rate_reg;
    logic          sat_reg;
    logic          out_valid_reg;
    gmi_pkg::res_t out_reg;

    logic          we;
    logic [AW-1:0] raddr;
    logic [31:0]   phys_q, cm_q;

    gmi_pkg::div_ctl_t div_ctl;
    gmi_pkg::div_sts_t div_sts;
    logic [127:0]      div_num;
    logic [63:0]       div_den, div_q;

    logic [CW-1:0] last_idx;
    logic [31:0]   mag, off, span, dg, dp;
    logic [63:0]   prod;
    logic          rate_sat;
    logic [63:0]   morg_prod;
    logic [31:0]   morg_rem;
    logic [19:0]   frac_prod;
    logic [38:0]   morg_full;

    assign we        = req.valid && req.ready && req.data.req_type == gmi_pkg::REQ_LOAD
                       && count_reg < CW'(MAP_DEPTH);
    assign req.ready = state_reg == S_IDLE && !out_valid_reg;
    assign last_idx  = count_reg - CW'(1);

    gmi_ram #(.WIDTH(32), .DEPTH(MAP_DEPTH)) u_phys (
        .clk(clk), .we(we), .waddr(count_reg[AW-1:0]), .wdata(req.data.position),
        .raddr(raddr), .rdata(phys_q)
    );
    gmi_ram #(.WIDTH(32), .DEPTH(MAP_DEPTH)) u_cm (
        .clk(clk), .we(we), .waddr(count_reg[AW-1:0]), .wdata(req.data.map_centimorgan),
        .raddr(raddr), .rdata(cm_q)
    );
    gmi_div u_div (
        .clk(clk), .rst_n(rst_n), .ctl(div_ctl), .dividend(div_num),
        .divisor(div_den), .sts(div_sts), .quotient(div_q)
    );

    // previous entry is in phys_q/cm_q during interpolation
    assign mag  = (c1_reg >= cm_q) ? c1_reg - cm_q : cm_q - c1_reg;
    assign off  = (bp_reg > phys_q) ? bp_reg - phys_q : 32'd0;
    assign span = p1_reg - phys_q;
    assign prod = mag * off;
    assign dg   = (g_reg > pg_reg) ? g_reg - pg_reg : 32'd0;
    assign dp   = (bp_reg > pp_reg) ? bp_reg - pp_reg : 32'd0;
    assign rate_sat = dp == '0 || {28'd0, dg[31:28]} >= dp;

    // cm * 4096 / 100 = (cm / 25) * 1024 + (cm % 25) * 1024 / 25
    assign morg_prod = cm_reg * MORG_RECIP;
    assign morg_rem  = cm_reg - {3'd0, morg_q_reg} * 32'd25;
    assign frac_prod = morg_rem[4:0] * FRAC_RECIP;
    assign morg_full = {morg_q_reg, frac_prod[19:10]};

    always_comb
    begin
        raddr       = cur_reg;
        div_ctl     = '0;
        div_num     = '0;
        div_den     = '0;
        state_next  = state_reg;
        if (state_reg == S_PREV || state_reg == S_PREVW || state_reg == S_INTP)
        begin
            raddr = cur_reg - AW'(1);
        end
        else if (state_reg == S_WALK && bp_reg > phys_q && {1'b0, cur_reg} < last_idx)
        begin
            raddr = cur_reg + AW'(1);
        end
        case (state_reg)
            S_INTP:
            begin
                div_ctl.start = 1'b1;
                div_num = {64'd0, prod};
                div_den = {32'd0, span};
            end
            S_RATE:
            begin
                if (!rate_sat)
                begin
                    div_ctl.start = 1'b1;
                    div_num = {60'd0, dg, 36'd0};
                    div_den = {32'd0, dp};
                end
            end
            default:
            begin
                div_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cur_reg       <= '0;
            mcnt_reg      <= '0;
            pg_reg        <= '0;
            pp_reg        <= '0;
            bp_reg        <= '0;
            p1_reg        <= '0;
            c1_reg        <= '0;
            cm_reg        <= '0;
            g_reg         <= '0;
            morg_q_reg    <= '0;
            rate_reg      <= '0;
            sat_reg       <= 1'b0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        bp_reg <= req.data.position;
                        if (req.data.req_type == gmi_pkg::REQ_LOAD)
                        begin
                            if (count_reg < CW'(MAP_DEPTH))
                            begin
                                count_reg <= count_reg + CW'(1);
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            out_reg       <= '{marker_index: '0, genetic_pos: '0,
                                               rec_rate: '0, rate_valid: 1'b0,
                                               rate_saturated: 1'b0, map_error: 1'b1,
                                               last: 1'b1};
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            if ({1'b0, cur_reg} > last_idx)
                            begin
                                cur_reg <= last_idx[AW-1:0];
                            end
                            state_reg <= S_RD;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_RDW;
                end
                S_RDW:
                begin
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    if (bp_reg > phys_q && {1'b0, cur_reg} < last_idx)
                    begin
                        cur_reg   <= cur_reg + AW'(1);
                        state_reg <= S_RDW;
                    end
                    else
                    begin
                        p1_reg <= phys_q;
                        c1_reg <= cm_q;
                        if (bp_reg >= phys_q || cur_reg == '0)
                        begin
                            cm_reg    <= cm_q;
                            state_reg <= S_MORG;
                        end
                        else
                        begin
                            state_reg <= S_PREV;
                        end
                    end
                end
                S_PREV:
                begin
                    state_reg <= S_PREVW;
                end
                S_PREVW:
                begin
                    if (p1_reg <= phys_q)
                    begin
                        cm_reg    <= cm_q;
                        state_reg <= S_MORG;
                    end
                    else
                    begin
                        cm_reg    <= cm_q;
                        state_reg <= S_INTP;
                    end
                end
                S_INTP:
                begin
                    // sign kept in c1_reg vs cm_reg
                    state_reg <= S_IWAIT;
                end
                S_IWAIT:
                begin
                    if (div_sts.done)
                    begin
                        cm_reg    <= (c1_reg >= cm_reg) ? cm_reg + div_q[31:0]
                                                        : cm_reg - div_q[31:0];
                        state_reg <= S_MORG;
                    end
                end
                S_MORG:
                begin
                    morg_q_reg <= morg_prod[63:35];
                    state_reg  <= S_MWAIT;
                end
                S_MWAIT:
                begin
                    g_reg     <= (morg_full[38:32] != '0) ? 32'hFFFF_FFFF : morg_full[31:0];
                    state_reg <= (mcnt_reg == '0) ? S_OUT : S_RATE;
                end
                S_RATE:
                begin
                    if (rate_sat)
                    begin
                        rate_reg  <= '1;
                        sat_reg   <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        sat_reg   <= 1'b0;
                        state_reg <= S_RWAIT;
                    end
                end
                S_RWAIT:
                begin
                    if (div_sts.done)
                    begin
                        rate_reg  <= div_q;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg          <= 1'b1;
                        out_reg.map_error      <= 1'b0;
                        out_reg.rate_valid     <= mcnt_reg != '0;
                        out_reg.rec_rate       <= (mcnt_reg != '0) ? rate_reg : 64'd0;
                        out_reg.rate_saturated <= (mcnt_reg != '0) && sat_reg;
                        if (mcnt_reg == 32'd1)
                        begin
                            out_reg.marker_index <= '0;
                            out_reg.genetic_pos  <= pg_reg;
                            out_reg.last         <= 1'b0;
                            state_reg            <= S_OUT2;
                        end
                        else
                        begin
                            out_reg.marker_index <= mcnt_reg;
                            out_reg.genetic_pos  <= g_reg;
                            out_reg.last         <= 1'b1;
                            pg_reg    <= g_reg;
                            pp_reg    <= bp_reg;
                            mcnt_reg  <= (mcnt_reg != '1) ? mcnt_reg + 32'd1 : mcnt_reg;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_OUT2:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg        <= 1'b1;
                        out_reg.marker_index <= mcnt_reg;
                        out_reg.genetic_pos  <= g_reg;
                        out_reg.last         <= 1'b1;
                        pg_reg    <= g_reg;
                        pp_reg    <= bp_reg;
                        mcnt_reg  <= mcnt_reg + 32'd1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAP_DEPTH)) else $error("entry count overflow");
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.start |-> !div_sts.busy) else $error("divider restarted");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res.ready |=> out_valid_reg && $stable(out_reg))
        else $error("result dropped");
`endif
endmodule
`default_nettype wire
